// File: src/swa_pkg.sv
`default_nettype none
package swa_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int IDX_W      = SLOT_W + 1;
    localparam int MAX_LEN    = 512;
    localparam int LEN_W      = 10;
    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 4;
    localparam int RTO_W      = 8;
    localparam int RESULT_CAP = 8;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);
    localparam int FLT_W      = $clog2(SLOTS + 1);

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [RTO_W-1:0] RTO_RESET = RTO_W'(5);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(SLOTS);

    typedef enum logic [2:0] {
        OP_RX_DATA = 3'd0,
        OP_RX_ACK  = 3'd1,
        OP_TICK    = 3'd2,
        OP_IDLE    = 3'd3,
        OP_ENQUEUE = 3'd4,
        OP_READ    = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_DATA     = 2'd1,
        KIND_ENQ_REPLY = 2'd2,
        KIND_RD_REPLY = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK_SCAN,
        ST_TICK_RD1,
        ST_TICK_CHK1,
        ST_TICK_PREP,
        ST_TICK_RD2,
        ST_TICK_CHK2,
        ST_READ_OUT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [WIN_W-1:0]  win;
        logic [SLOT_W-1:0] slot;
        logic              acc;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
    } send_ent_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
    } recv_ent_t;

endpackage
`default_nettype wire

// File: src/swa_ram.sv
`default_nettype none
module swa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/sliding_window_arq_engine_core.sv
// Go-back-N connection engine. Input beats arrive on s_axis: tuser holds the
// opcode, tdata the segment fields. Result beats leave on m_axis: tuser holds
// the result kind, tlast marks the final result of one input beat. The retransmit
// timeout is written through the cfg channel, which is always ready.
// Receive data, idle timeout, enqueue and a failed app read are answered
// from the idle state; a good app read adds one receive-table read; an ACK
// does one send-table read per slot through a pipelined scan; a send tick
// makes two passes over the slots, and in each pass every candidate slot is
// read from the send table, checked and possibly written back before the next
// one is read.
// Each result is held one beat back so that tlast can be set on the final one.
// Reset empties both slot tables (occupancy is kept in flip-flops, so the RAMs
// need no clearing pass), restores both windows to eight and the timeout to 5.
// When the receiver stalls, results wait in the output register and the held
// stage, and the engine stalls with them; a new input beat is taken once the
// current one has delivered all but its result in the output register.
`default_nettype none
module sliding_window_arq_engine_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [swa_pkg::RTO_W-1:0]        cfg_data,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // seq_number[15:0], length[25:16], peer_window[29:26],
    // now_seconds[61:30], read_slot[64:62], zero fill above
    input  wire logic [swa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode[2:0]
    input  wire logic [2:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_seq[15:0], out_length[25:16], own_window[29:26],
    // slot_index[32:30], accepted[33], zero fill above
    output logic [swa_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);

    import swa_pkg::*;

    // Input field unpacking.
    logic [SEQ_W-1:0]  in_seq;
    logic [LEN_W-1:0]  in_len;
    logic [WIN_W-1:0]  in_pwin;
    logic [TIME_W-1:0] in_now;
    logic [SLOT_W-1:0] in_rslot;
    opcode_t           in_op;

    assign in_seq   = s_axis_tdata[15:0];
    assign in_len   = s_axis_tdata[25:16];
    assign in_pwin  = s_axis_tdata[29:26];
    assign in_now   = s_axis_tdata[61:30];
    assign in_rslot = s_axis_tdata[64:62];
    assign in_op    = opcode_t'(s_axis_tuser);

    // Control and connection state.
    state_t            state_reg, state_next;
    logic [RTO_W-1:0]  rto_reg;
    logic [SLOTS-1:0]  send_occ_reg, send_occ_next;
    logic [SLOTS-1:0]  send_sent_reg, send_sent_next;
    logic [SLOTS-1:0]  recv_occ_reg, recv_occ_next;
    logic [WIN_W-1:0]  send_win_reg, send_win_next;
    logic [WIN_W-1:0]  recv_win_reg, recv_win_next;
    logic [SEQ_W-1:0]  last_acked_reg, last_acked_next;
    logic              no_space_reg, no_space_next;

    // Per-item scan state.
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0] chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [FLT_W-1:0]  flight_reg, flight_next;
    logic [WIN_W-1:0]  eff_reg, eff_next;

    // Latched input fields.
    logic [SEQ_W-1:0]  seq_in_reg, seq_in_next;
    logic [WIN_W-1:0]  pwin_in_reg, pwin_in_next;
    logic [TIME_W-1:0] now_in_reg, now_in_next;
    logic [SLOT_W-1:0] rslot_in_reg, rslot_in_next;

    // Held result and output register.
    logic              pend_vld_reg, pend_vld_next;
    res_t              pend_reg, pend_next;
    logic              out_vld_reg, out_vld_next;
    res_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;

    // Memory ports.
    logic              s_we, s_re, r_we, r_re;
    logic [SLOT_W-1:0] s_waddr, s_raddr, r_waddr, r_raddr;
    send_ent_t         s_wdata, s_rdata;
    recv_ent_t         r_wdata, r_rdata;

    // Helpers.
    logic              out_free, can_put, put_en, flush_en;
    res_t              put_res;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] recv_free_slot, send_free_slot;
    logic              recv_free_found, send_free_found;
    logic              len_ok;
    logic [RTO_W-1:0]  thr;
    logic [TIME_W:0]   due_time;
    logic              expired;
    logic [SEQ_W-1:0]  ack_diff;
    logic [FLT_W-1:0]  flight_cnt;
    logic              unsent_any;
    logic [WIN_W-1:0]  recv_win_dec;
    logic              in_fire;

    swa_ram #(
        .WIDTH ($bits(send_ent_t)),
        .DEPTH (SLOTS)
    ) u_send_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    swa_ram #(
        .WIDTH ($bits(recv_ent_t)),
        .DEPTH (SLOTS)
    ) u_recv_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {6'd0, out_reg.acc, out_reg.slot, out_reg.win,
                            out_reg.len, out_reg.seq};

    assign out_free = !out_vld_reg || m_axis_tready;
    assign can_put  = !pend_vld_reg || out_free;
    assign cur      = idx_reg[SLOT_W-1:0];
    assign len_ok   = (in_len != '0) && (in_len <= LEN_W'(MAX_LEN));
    assign recv_win_dec = (recv_win_reg != '0) ? recv_win_reg - 1'b1 : recv_win_reg;

    // A slot is due when the timeout (one while the send window is zero) is zero or
    // now reaches stamp plus timeout; with a nonzero timeout, a stamp in the future never counts as elapsed.
    assign thr      = (send_win_reg == '0) ? RTO_W'(1) : rto_reg;
    assign due_time = {1'b0, s_rdata.stamp} + (TIME_W+1)'(thr);
    assign expired  = (thr == '0) || ({1'b0, now_in_reg} >= due_time);
    assign ack_diff = seq_in_reg - s_rdata.seq;

    // Lowest free slots in each table.
    always_comb
    begin
        recv_free_found = 1'b0;
        recv_free_slot  = '0;
        send_free_found = 1'b0;
        send_free_slot  = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (!recv_occ_reg[j] && !recv_free_found)
            begin
                recv_free_found = 1'b1;
                recv_free_slot  = SLOT_W'(j);
            end
            if (!send_occ_reg[j] && !send_free_found)
            begin
                send_free_found = 1'b1;
                send_free_slot  = SLOT_W'(j);
            end
        end
    end

    always_comb
    begin
        flight_cnt = '0;
        unsent_any = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (send_occ_reg[j] && send_sent_reg[j])
            begin
                flight_cnt = flight_cnt + 1'b1;
            end
            if (send_occ_reg[j] && !send_sent_reg[j])
            begin
                unsent_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        send_occ_next   = send_occ_reg;
        send_sent_next  = send_sent_reg;
        recv_occ_next   = recv_occ_reg;
        send_win_next   = send_win_reg;
        recv_win_next   = recv_win_reg;
        last_acked_next = last_acked_reg;
        no_space_next   = no_space_reg;
        idx_next        = idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        n_next          = n_reg;
        flight_next     = flight_reg;
        eff_next        = eff_reg;
        seq_in_next     = seq_in_reg;
        pwin_in_next    = pwin_in_reg;
        now_in_next     = now_in_reg;
        rslot_in_next   = rslot_in_reg;
        put_en          = 1'b0;
        put_res         = '0;
        put_res.win     = recv_win_reg;
        flush_en        = 1'b0;
        s_we            = 1'b0;
        s_waddr         = cur;
        s_wdata         = s_rdata;
        s_re            = 1'b0;
        s_raddr         = cur;
        r_we            = 1'b0;
        r_waddr         = recv_free_slot;
        r_wdata         = '{len: in_len, seq: in_seq};
        r_re            = 1'b0;
        r_raddr         = in_rslot;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    seq_in_next   = in_seq;
                    pwin_in_next  = in_pwin;
                    now_in_next   = in_now;
                    rslot_in_next = in_rslot;
                    idx_next      = '0;
                    n_next        = '0;
                    state_next    = ST_FLUSH;
                    unique case (in_op)
                        OP_RX_DATA:
                        begin
                            no_space_next = 1'b0;
                            put_en        = 1'b1;
                            put_res.kind  = KIND_ACK;
                            if ((in_seq == last_acked_reg + 1'b1) && len_ok && recv_free_found)
                            begin
                                r_we          = 1'b1;
                                recv_occ_next[recv_free_slot] = 1'b1;
                                recv_win_next = recv_win_dec;
                                last_acked_next = in_seq;
                                no_space_next = (recv_win_dec == '0);
                                put_res.seq   = in_seq;
                                put_res.len   = in_len;
                                put_res.win   = recv_win_dec;
                                put_res.slot  = recv_free_slot;
                                put_res.acc   = 1'b1;
                            end
                            else
                            begin
                                put_res.seq = last_acked_reg;
                            end
                        end
                        OP_RX_ACK:
                        begin
                            state_next = ST_ACK_SCAN;
                        end
                        OP_TICK:
                        begin
                            state_next = ST_TICK_RD1;
                        end
                        OP_IDLE:
                        begin
                            if (no_space_reg && (recv_win_reg != '0))
                            begin
                                put_en       = 1'b1;
                                put_res.kind = KIND_ACK;
                                put_res.seq  = last_acked_reg;
                            end
                        end
                        OP_ENQUEUE:
                        begin
                            put_en       = 1'b1;
                            put_res.kind = KIND_ENQ_REPLY;
                            put_res.seq  = in_seq;
                            put_res.len  = in_len;
                            if (len_ok && send_free_found)
                            begin
                                s_we    = 1'b1;
                                s_waddr = send_free_slot;
                                s_wdata = '{len: in_len, seq: in_seq, stamp: '0};
                                send_occ_next[send_free_slot]  = 1'b1;
                                send_sent_next[send_free_slot] = 1'b0;
                                put_res.slot = send_free_slot;
                                put_res.acc  = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (recv_occ_reg[in_rslot])
                            begin
                                r_re       = 1'b1;
                                recv_occ_next[in_rslot] = 1'b0;
                                if (recv_win_reg < WIN_W'(SLOTS))
                                begin
                                    recv_win_next = recv_win_reg + 1'b1;
                                end
                                state_next = ST_READ_OUT;
                            end
                            else
                            begin
                                put_en       = 1'b1;
                                put_res.kind = KIND_RD_REPLY;
                                put_res.slot = in_rslot;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            // Read one slot per cycle; each compare follows in the cycle after its read.
            ST_ACK_SCAN:
            begin
                if (idx_reg < IDX_W'(SLOTS))
                begin
                    s_re         = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = cur;
                    idx_next     = idx_reg + 1'b1;
                end
                if (chk_vld_reg && !ack_diff[SEQ_W-1])
                begin
                    send_occ_next[chk_idx_reg] = 1'b0;
                end
                if ((idx_reg == IDX_W'(SLOTS)) && !chk_vld_reg)
                begin
                    send_sent_next = '0;
                    send_win_next  = pwin_in_reg;
                    state_next     = ST_FLUSH;
                end
            end

            ST_TICK_RD1:
            begin
                if ((idx_reg == IDX_W'(SLOTS)) || (n_reg == CNT_W'(RESULT_CAP)))
                begin
                    state_next = ST_TICK_PREP;
                end
                else if (send_occ_reg[cur] && send_sent_reg[cur])
                begin
                    s_re       = 1'b1;
                    state_next = ST_TICK_CHK1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_TICK_CHK1:
            begin
                if (!expired)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_TICK_RD1;
                end
                else if (can_put)
                begin
                    put_en        = 1'b1;
                    put_res.kind  = KIND_DATA;
                    put_res.seq   = s_rdata.seq;
                    put_res.len   = s_rdata.len;
                    put_res.slot  = cur;
                    s_we          = 1'b1;
                    s_wdata.stamp = now_in_reg;
                    n_next        = n_reg + 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = ST_TICK_RD1;
                end
            end

            // In-flight count and effective window for the sending pass.
            ST_TICK_PREP:
            begin
                flight_next = flight_cnt;
                eff_next    = send_win_reg;
                if ((send_win_reg == '0) && unsent_any && (flight_cnt == '0))
                begin
                    eff_next = WIN_W'(1);
                end
                idx_next   = '0;
                state_next = ST_TICK_RD2;
            end

            ST_TICK_RD2:
            begin
                if ((idx_reg == IDX_W'(SLOTS)) || (n_reg == CNT_W'(RESULT_CAP)))
                begin
                    state_next = ST_FLUSH;
                end
                else if (send_occ_reg[cur] && !send_sent_reg[cur] && (eff_reg != '0)
                         && (WIN_W'(flight_reg) < eff_reg))
                begin
                    s_re       = 1'b1;
                    state_next = ST_TICK_CHK2;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_TICK_CHK2:
            begin
                if (can_put)
                begin
                    put_en       = 1'b1;
                    put_res.kind = KIND_DATA;
                    put_res.seq  = s_rdata.seq;
                    put_res.len  = s_rdata.len;
                    put_res.slot = cur;
                    n_next       = n_reg + 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    if (send_win_reg != '0)
                    begin
                        send_sent_next[cur] = 1'b1;
                        s_we          = 1'b1;
                        s_wdata.stamp = now_in_reg;
                        flight_next   = flight_reg + 1'b1;
                        state_next    = ST_TICK_RD2;
                    end
                    else
                    begin
                        // A zero-window probe ends the pass and stays unsent.
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_READ_OUT:
            begin
                put_en       = 1'b1;
                put_res.kind = KIND_RD_REPLY;
                put_res.seq  = r_rdata.seq;
                put_res.len  = r_rdata.len;
                put_res.slot = rslot_in_reg;
                put_res.acc  = 1'b1;
                state_next   = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_en   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The held result moves to the output register when a newer one arrives
    // (not last) or when the item is finished (last).
    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        if (put_en)
        begin
            if (pend_vld_reg)
            begin
                out_vld_next  = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_next     = put_res;
        end
        else if (flush_en)
        begin
            out_vld_next  = 1'b1;
            out_next      = pend_reg;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rto_reg        <= RTO_RESET;
            send_occ_reg   <= '0;
            send_sent_reg  <= '0;
            recv_occ_reg   <= '0;
            send_win_reg   <= WIN_RESET;
            recv_win_reg   <= WIN_RESET;
            last_acked_reg <= '0;
            no_space_reg   <= 1'b0;
            chk_vld_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                rto_reg <= cfg_data;
            end
            send_occ_reg   <= send_occ_next;
            send_sent_reg  <= send_sent_next;
            recv_occ_reg   <= recv_occ_next;
            send_win_reg   <= send_win_next;
            recv_win_reg   <= recv_win_next;
            last_acked_reg <= last_acked_next;
            no_space_reg   <= no_space_next;
            chk_vld_reg    <= chk_vld_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        chk_idx_reg  <= chk_idx_next;
        n_reg        <= n_next;
        flight_reg   <= flight_next;
        eff_reg      <= eff_next;
        seq_in_reg   <= seq_in_next;
        pwin_in_reg  <= pwin_in_next;
        now_in_reg   <= now_in_next;
        rslot_in_reg <= rslot_in_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule
`default_nettype wire
